@@ rtl/core/skf_pkg.sv @@
// Shared types, codes and microcode store for the scalar Kalman filter core.
package skf_pkg;

    // Reset values of the noise registers, in whole units before scaling.
    localparam int PROCESS_NOISE_RESET     = 10;
    localparam int MEASUREMENT_NOISE_RESET = 40;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;

    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_WAIT_IN = 3'd1,
        OP_DIV     = 3'd2,
        OP_GAIN    = 3'd3,
        OP_MUL     = 3'd4,
        OP_MUL_TOP = 3'd5,
        OP_UPDATE  = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        HOLD_NONE      = 2'd0,
        HOLD_NO_ACCEPT = 2'd1,
        HOLD_LOOP      = 2'd2,
        HOLD_OUT_BUSY  = 2'd3
    } hold_t;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT    = 3'd0;
    localparam step_t STEP_DIV     = 3'd1;
    localparam step_t STEP_GAIN    = 3'd2;
    localparam step_t STEP_MUL     = 3'd3;
    localparam step_t STEP_MUL_TOP = 3'd4;
    localparam step_t STEP_UPDATE  = 3'd5;

    typedef struct packed {
        op_t   op;
        hold_t hold;
        step_t next_step;
    } ucode_t;

    typedef struct packed {
        op_t  op;
        logic accept;
    } ctrl_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    // A step repeats while its hold condition is true, then goes to next_step.
    function automatic ucode_t ucode_rom(step_t step);
        ucode_t word;
        unique case (step)
            STEP_WAIT:    word = '{op: OP_WAIT_IN, hold: HOLD_NO_ACCEPT, next_step: STEP_DIV};
            STEP_DIV:     word = '{op: OP_DIV,     hold: HOLD_LOOP,      next_step: STEP_GAIN};
            STEP_GAIN:    word = '{op: OP_GAIN,    hold: HOLD_NONE,      next_step: STEP_MUL};
            STEP_MUL:     word = '{op: OP_MUL,     hold: HOLD_LOOP,      next_step: STEP_MUL_TOP};
            STEP_MUL_TOP: word = '{op: OP_MUL_TOP, hold: HOLD_NONE,      next_step: STEP_UPDATE};
            STEP_UPDATE:  word = '{op: OP_UPDATE,  hold: HOLD_OUT_BUSY,  next_step: STEP_WAIT};
            default:      word = '{op: OP_NOP,     hold: HOLD_NONE,      next_step: STEP_WAIT};
        endcase
        return word;
    endfunction

endpackage

@@ rtl/core/skf_sequencer.sv @@
// Microcode sequencer: step counter, loop counter and control store lookup.
module skf_sequencer #(
    parameter int LOOP_COUNT = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  skf_pkg::status_t  status,
    output skf_pkg::ctrl_t    ctrl
);

    localparam int CNT_W = $clog2(LOOP_COUNT);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LOOP_COUNT - 1);

    skf_pkg::step_t   pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    skf_pkg::ucode_t  word;
    logic             accept;
    logic             hold;
    logic             loop_done;

    assign word      = skf_pkg::ucode_rom(pc_reg);
    assign s_ready   = (word.op == skf_pkg::OP_WAIT_IN);
    assign accept    = s_valid & s_ready;
    assign loop_done = (cnt_reg == CNT_LAST);

    assign ctrl.op     = word.op;
    assign ctrl.accept = accept;

    always_comb begin
        cnt_next = cnt_reg;
        unique case (word.hold)
            skf_pkg::HOLD_NONE:      hold = 1'b0;
            skf_pkg::HOLD_NO_ACCEPT: hold = ~accept;
            skf_pkg::HOLD_LOOP: begin
                hold     = ~loop_done;
                cnt_next = loop_done ? '0 : cnt_reg + 1'b1;
            end
            skf_pkg::HOLD_OUT_BUSY:  hold = status.out_busy;
            default:                 hold = 1'b0;
        endcase
        pc_next = hold ? pc_reg : word.next_step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= skf_pkg::STEP_WAIT;
            cnt_reg <= '0;
        end else begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ rtl/core/skf_datapath.sv @@
// Datapath: noise registers, filter state, restoring divider, shift-add multipliers.
module skf_datapath #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  skf_pkg::ctrl_t                      ctrl,
    output skf_pkg::status_t                    status,
    input  logic                                cfg_wr_en,
    input  logic [skf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [DATA_WIDTH-1:0]               cfg_data,
    input  logic signed [DATA_WIDTH-1:0]        s_measurement,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [DATA_WIDTH-1:0]        m_estimate
);

    localparam int D = DATA_WIDTH;
    localparam int F = FRAC_BITS;
    localparam logic [D-1:0] Q_RESET =
        D'(64'(skf_pkg::PROCESS_NOISE_RESET) << F);
    localparam logic [D-1:0] R_RESET =
        D'(64'(skf_pkg::MEASUREMENT_NOISE_RESET) << F);
    localparam logic [F:0] GAIN_ONE = {1'b1, {F{1'b0}}};

    logic [D-1:0] q_reg, q_next;
    logic [D-1:0] r_reg, r_next;
    logic [D-1:0] x_reg, x_next;
    logic [D-1:0] p_reg, p_next;
    logic         m_valid_reg, m_valid_next;
    logic [D-1:0] est_reg, est_next;
    logic [D-1:0] mag_reg, mag_next;
    logic         neg_reg, neg_next;
    logic [D:0]   rem_reg, rem_next;
    logic [D:0]   d_reg, d_next;
    logic [F:0]   k_reg, k_next;
    logic [D-1:0] acc_e_reg, acc_e_next;
    logic [D-1:0] acc_p_reg, acc_p_next;

    logic [D:0]   diff;
    logic [D:0]   diff_neg;
    logic [D+1:0] rem_sh;
    logic [D+1:0] rem_sub;
    logic         rem_fits;
    logic [D:0]   add_e;
    logic [D:0]   add_p;
    logic [D-1:0] upd_x;
    logic [D-1:0] p_less;
    logic [D:0]   p_sum;
    logic         out_busy;

    assign diff     = {s_measurement[D-1], s_measurement} - {x_reg[D-1], x_reg};
    assign diff_neg = ~diff + 1'b1;
    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_sub  = rem_sh - {1'b0, d_reg};
    assign rem_fits = (rem_sh >= {1'b0, d_reg});
    assign add_e    = {1'b0, acc_e_reg} + (k_reg[0] ? {1'b0, mag_reg} : '0);
    assign add_p    = {1'b0, acc_p_reg} + (k_reg[0] ? {1'b0, p_reg} : '0);
    // The step never exceeds the distance to the measurement, so this cannot wrap.
    assign upd_x    = neg_reg ? x_reg - acc_e_reg : x_reg + acc_e_reg;
    assign p_less   = p_reg - acc_p_reg;
    assign p_sum    = {1'b0, p_less} + {1'b0, q_reg};
    assign out_busy = m_valid_reg & ~m_ready;

    assign status.out_busy = out_busy;
    assign m_valid         = m_valid_reg;
    assign m_estimate      = $signed(est_reg);

    always_comb begin
        q_next       = q_reg;
        r_next       = r_reg;
        x_next       = x_reg;
        p_next       = p_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        est_next     = est_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        rem_next     = rem_reg;
        d_next       = d_reg;
        k_next       = k_reg;
        acc_e_next   = acc_e_reg;
        acc_p_next   = acc_p_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                skf_pkg::REG_PROCESS_NOISE:     q_next = cfg_data;
                skf_pkg::REG_MEASUREMENT_NOISE: r_next = cfg_data;
                default: ;
            endcase
        end

        unique case (ctrl.op)
            skf_pkg::OP_WAIT_IN: begin
                if (ctrl.accept) begin
                    neg_next = diff[D];
                    mag_next = diff[D] ? diff_neg[D-1:0] : diff[D-1:0];
                    rem_next = {1'b0, p_reg};
                    d_next   = {1'b0, p_reg} + {1'b0, r_reg};
                    k_next   = '0;
                end
            end
            skf_pkg::OP_DIV: begin
                if (rem_fits) begin
                    rem_next = rem_sub[D:0];
                end else begin
                    rem_next = rem_sh[D:0];
                end
                k_next = {k_reg[F-1:0], rem_fits};
            end
            skf_pkg::OP_GAIN: begin
                // A zero variance always gives zero gain, even with no measurement
                // noise; otherwise no measurement noise gives a gain of exactly one.
                if (p_reg == '0) begin
                    k_next = '0;
                end else if (r_reg == '0) begin
                    k_next = GAIN_ONE;
                end
                acc_e_next = '0;
                acc_p_next = '0;
            end
            skf_pkg::OP_MUL: begin
                acc_e_next = add_e[D:1];
                acc_p_next = add_p[D:1];
                k_next     = k_reg >> 1;
            end
            skf_pkg::OP_MUL_TOP: begin
                // The last gain bit has weight one, so it is added without a shift.
                acc_e_next = add_e[D-1:0];
                acc_p_next = add_p[D-1:0];
            end
            skf_pkg::OP_UPDATE: begin
                if (!out_busy) begin
                    x_next       = upd_x;
                    p_next       = p_sum[D] ? '1 : p_sum[D-1:0];
                    est_next     = upd_x;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg       <= Q_RESET;
            r_reg       <= R_RESET;
            x_reg       <= '0;
            p_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            q_reg       <= q_next;
            r_reg       <= r_next;
            x_reg       <= x_next;
            p_reg       <= p_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        est_reg   <= est_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        rem_reg   <= rem_next;
        d_reg     <= d_next;
        k_reg     <= k_next;
        acc_e_reg <= acc_e_next;
        acc_p_reg <= acc_p_next;
    end

endmodule

@@ rtl/core/scalar_kalman_filter_core.sv @@
// Top level of the scalar Kalman filter core: sequencer and datapath.
//
//   Channel      Direction  Handshake            Payload
//   s_ (sample)  in         s_valid / s_ready    s_measurement, signed fixed point
//   m_ (result)  out        m_valid / m_ready    m_estimate, signed fixed point
//   cfg          in         cfg_wr_en            cfg_index, cfg_data
//
// From transfer to a loaded result register, each sample passes through FRAC_BITS
// restoring divide steps for the gain, then FRAC_BITS+1 shift-add steps of the
// multiplier pair that scales both updates.
// The next sample is taken in the cycle after the result register is loaded.
// A result held by m_ready low stalls only the final update step.
// Reset is synchronous and clears the estimate and variance to zero.
module scalar_kalman_filter_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [DATA_WIDTH-1:0]        s_measurement,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [DATA_WIDTH-1:0]        m_estimate,
    input  logic                                cfg_wr_en,
    input  logic [skf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [DATA_WIDTH-1:0]               cfg_data
);

    skf_pkg::ctrl_t   ctrl;
    skf_pkg::status_t status;

    skf_sequencer #(
        .LOOP_COUNT (FRAC_BITS)
    ) u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    skf_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_measurement (s_measurement),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_estimate    (m_estimate)
    );

endmodule
